// ===== hw/rtl/tbs_pkg.sv =====
// ----------------------------------------------------------------------------
// Token bucket shaper package
// Shared payload types, queue sizes and event codes for the shaper.
// ----------------------------------------------------------------------------
package tbs_pkg;

   // Queue sizes and the pointer and count widths that follow from them
   localparam int unsigned WAIT_DEPTH   = 64;
   localparam int unsigned READY_DEPTH  = 64;
   localparam int unsigned WAIT_PTR_W   = $clog2(WAIT_DEPTH);
   localparam int unsigned WAIT_CNT_W   = $clog2(WAIT_DEPTH + 1);
   localparam int unsigned READY_PTR_W  = $clog2(READY_DEPTH);
   localparam int unsigned READY_CNT_W  = $clog2(READY_DEPTH + 1);

   // Request kinds
   localparam logic [1:0] FUNC_ARRIVE = 2'd0;
   localparam logic [1:0] FUNC_TICK   = 2'd1;
   localparam logic [1:0] FUNC_SERVE  = 2'd2;

   // Result events
   localparam logic [2:0] EV_DROP_BIG  = 3'd0;
   localparam logic [2:0] EV_DROP_FULL = 3'd1;
   localparam logic [2:0] EV_ENTER_Q1  = 3'd2;
   localparam logic [2:0] EV_TO_Q2     = 3'd3;
   localparam logic [2:0] EV_TOK_DROP  = 3'd4;
   localparam logic [2:0] EV_TOK_ADD   = 3'd5;
   localparam logic [2:0] EV_SERVICE   = 3'd6;
   localparam logic [2:0] EV_Q2_EMPTY  = 3'd7;

   localparam logic [15:0] CAPACITY_RESET = 16'd10;

   typedef struct packed {
      logic [1:0]  func;
      logic [15:0] token_demand;
      logic [15:0] service_time;
      logic        server_id;
   } req_type;

   typedef struct packed {
      logic [2:0]  event_res;
      logic [15:0] item_number;
      logic [15:0] packet_tokens;
      logic [15:0] packet_service_time;
      logic        serving_unit;
      logic [15:0] bucket_level;
      logic        last;
   } rsp_type;

   // One queued packet
   typedef struct packed {
      logic [15:0] num;
      logic [15:0] tok;
      logic [15:0] svc;
   } pkt_type;

endpackage

// ===== hw/rtl/token_bucket_shaper_top.sv =====
// ----------------------------------------------------------------------------
// Token bucket shaper, top level
// Packets wait in Q1 until the bucket covers them, then move to Q2 for the
// servers. Both queues live in synchronous memories with a registered read.
// ----------------------------------------------------------------------------
// Flow: a request is held in the exec state, where its update commits and its first
//   result enters the result register; a second result follows from the second state.
//   Output back-pressure holds either state; no new request is taken until idle.
// Reset: synchronous; clears bucket, counters and queue pointers, capacity
//   returns to 10. Queue memories are not cleared.
module token_bucket_shaper_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  tbs_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output tbs_pkg::rsp_type rsp_data,
   input  logic             csr_wr_en,
   input  logic [15:0]      csr_wr_data
);
   import tbs_pkg::*;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_EXEC   = 2'd1;
   localparam logic [1:0] ST_SECOND = 2'd2;

   localparam logic [WAIT_PTR_W-1:0]  WAIT_LAST   = WAIT_PTR_W'(WAIT_DEPTH - 1);
   localparam logic [READY_PTR_W-1:0] READY_LAST  = READY_PTR_W'(READY_DEPTH - 1);
   localparam logic [WAIT_CNT_W-1:0]  WAIT_FULL   = WAIT_CNT_W'(WAIT_DEPTH);
   localparam logic [READY_CNT_W-1:0] READY_FULL  = READY_CNT_W'(READY_DEPTH);

   logic [1:0]  state_ff, state_in;
   req_type     req_ff;
   logic [15:0] capacity_ff;
   logic [15:0] level_ff, level_in;
   logic [15:0] pkt_cnt_ff, pkt_cnt_in;
   logic [15:0] tok_cnt_ff, tok_cnt_in;

   logic [WAIT_PTR_W-1:0]  wait_head_ff, wait_tail_ff;
   logic [WAIT_CNT_W-1:0]  wait_count_ff;
   logic [READY_PTR_W-1:0] ready_head_ff, ready_tail_ff;
   logic [READY_CNT_W-1:0] ready_count_ff;

   pkt_type wait_mem  [WAIT_DEPTH];
   pkt_type ready_mem [READY_DEPTH];
   pkt_type wait_rd_ff, ready_rd_ff;

   rsp_type first_rsp, second_in, second_ff;
   logic    has_second;
   logic    wait_push, wait_pop, ready_push, ready_pop;
   pkt_type new_pkt, move_pkt;
   logic    move_ok;
   logic [15:0] level_up;

   logic    out_valid, out_ready;
   rsp_type out_data;
   logic    commit;

   assign req_ready = (state_ff == ST_IDLE);

   // Capacity register
   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAPACITY_RESET;
      end else if (csr_wr_en) begin
         capacity_ff <= csr_wr_data;
      end
   end

   // Hold the request beat for the update cycle
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_ff <= req_data;
      end
   end

   // Read both queue heads every cycle; data is ready in the update cycle
   always_ff @(posedge clock) begin
      wait_rd_ff  <= wait_mem[wait_head_ff];
      ready_rd_ff <= ready_mem[ready_head_ff];
   end

   // Write back queue entries
   always_ff @(posedge clock) begin
      if (commit && wait_push) begin
         wait_mem[wait_tail_ff] <= new_pkt;
      end
      if (commit && ready_push) begin
         ready_mem[ready_tail_ff] <= move_pkt;
      end
   end

   // Decide the results and state updates for the held request
   always_comb begin
      pkt_cnt_in = pkt_cnt_ff + 16'd1;
      tok_cnt_in = tok_cnt_ff + 16'd1;
      level_up   = level_ff + 16'd1;
      new_pkt    = '{num: pkt_cnt_in, tok: req_ff.token_demand,
                     svc: req_ff.service_time};
      move_pkt   = wait_rd_ff;
      move_ok    = 1'b0;
      level_in   = level_ff;
      wait_push  = 1'b0;
      wait_pop   = 1'b0;
      ready_push = 1'b0;
      ready_pop  = 1'b0;
      first_rsp  = '0;
      second_in  = '0;
      has_second = 1'b0;

      unique case (req_ff.func)
         FUNC_ARRIVE: begin
            first_rsp.item_number         = pkt_cnt_in;
            first_rsp.packet_tokens       = req_ff.token_demand;
            first_rsp.packet_service_time = req_ff.service_time;
            if (req_ff.token_demand > capacity_ff) begin
               first_rsp.event_res = EV_DROP_BIG;
            end else if (wait_count_ff == WAIT_FULL) begin
               first_rsp.event_res = EV_DROP_FULL;
            end else begin
               first_rsp.event_res = EV_ENTER_Q1;
               wait_push = 1'b1;
               // Forward the new packet when it lands alone in Q1, Q2 has room and the bucket covers it
               move_pkt  = new_pkt;
               move_ok   = (wait_count_ff == '0) && (ready_count_ff != READY_FULL) &&
                           (req_ff.token_demand <= level_ff);
               if (move_ok) begin
                  level_in = level_ff - req_ff.token_demand;
               end
            end
            first_rsp.bucket_level = level_ff;
         end
         FUNC_TICK: begin
            first_rsp.item_number = tok_cnt_in;
            if (level_ff >= capacity_ff) begin
               first_rsp.event_res    = EV_TOK_DROP;
               first_rsp.bucket_level = level_ff;
            end else begin
               first_rsp.event_res    = EV_TOK_ADD;
               first_rsp.bucket_level = level_up;
               move_ok  = (wait_count_ff != '0) && (ready_count_ff != READY_FULL) &&
                          (wait_rd_ff.tok <= level_up);
               level_in = move_ok ? (level_up - wait_rd_ff.tok) : level_up;
            end
         end
         FUNC_SERVE: begin
            first_rsp.bucket_level = level_ff;
            if (ready_count_ff == '0) begin
               first_rsp.event_res = EV_Q2_EMPTY;
            end else begin
               ready_pop                     = 1'b1;
               first_rsp.event_res           = EV_SERVICE;
               first_rsp.item_number         = ready_rd_ff.num;
               first_rsp.packet_tokens       = ready_rd_ff.tok;
               first_rsp.packet_service_time = ready_rd_ff.svc;
               first_rsp.serving_unit        = req_ff.server_id;
            end
         end
         default: begin
         end
      endcase

      // Move the Q1 head into Q2
      if (move_ok) begin
         wait_pop                      = 1'b1;
         ready_push                    = 1'b1;
         has_second                    = 1'b1;
         second_in.event_res           = EV_TO_Q2;
         second_in.item_number         = move_pkt.num;
         second_in.packet_tokens       = move_pkt.tok;
         second_in.packet_service_time = move_pkt.svc;
         second_in.bucket_level        = level_in;
         second_in.last                = 1'b1;
      end
      first_rsp.last = !has_second;
   end

   // Sequence the update and result beats
   always_comb begin
      state_in  = state_ff;
      commit    = 1'b0;
      out_valid = 1'b0;
      out_data  = first_rsp;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (req_ff.func != FUNC_ARRIVE && req_ff.func != FUNC_TICK &&
                req_ff.func != FUNC_SERVE) begin
               // Unused kind: drop without a result
               state_in = ST_IDLE;
            end else begin
               out_valid = 1'b1;
               if (out_ready) begin
                  commit   = 1'b1;
                  state_in = has_second ? ST_SECOND : ST_IDLE;
               end
            end
         end
         ST_SECOND: begin
            out_valid = 1'b1;
            out_data  = second_ff;
            if (out_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold the second result until the output slot frees
   always_ff @(posedge clock) begin
      if (commit) begin
         second_ff <= second_in;
      end
   end

   // Advance control state, counters and queue pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         level_ff       <= '0;
         pkt_cnt_ff     <= '0;
         tok_cnt_ff     <= '0;
         wait_head_ff   <= '0;
         wait_tail_ff   <= '0;
         wait_count_ff  <= '0;
         ready_head_ff  <= '0;
         ready_tail_ff  <= '0;
         ready_count_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (commit) begin
            level_ff <= level_in;
            if (req_ff.func == FUNC_ARRIVE) begin
               pkt_cnt_ff <= pkt_cnt_in;
            end
            if (req_ff.func == FUNC_TICK) begin
               tok_cnt_ff <= tok_cnt_in;
            end
            if (wait_push) begin
               wait_tail_ff <= (wait_tail_ff == WAIT_LAST) ? '0 : wait_tail_ff + 1'b1;
            end
            if (wait_pop) begin
               wait_head_ff <= (wait_head_ff == WAIT_LAST) ? '0 : wait_head_ff + 1'b1;
            end
            if (wait_push && !wait_pop) begin
               wait_count_ff <= wait_count_ff + 1'b1;
            end else if (wait_pop && !wait_push) begin
               wait_count_ff <= wait_count_ff - 1'b1;
            end
            if (ready_push) begin
               ready_tail_ff <= (ready_tail_ff == READY_LAST) ? '0 : ready_tail_ff + 1'b1;
            end
            if (ready_pop) begin
               ready_head_ff <= (ready_head_ff == READY_LAST) ? '0 : ready_head_ff + 1'b1;
            end
            if (ready_push && !ready_pop) begin
               ready_count_ff <= ready_count_ff + 1'b1;
            end else if (ready_pop && !ready_push) begin
               ready_count_ff <= ready_count_ff - 1'b1;
            end
         end
      end
   end

   // Result register toward the consumer
   tbs_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (out_valid),
      .in_ready  (out_ready),
      .in_data   (out_data),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

endmodule

// ===== hw/rtl/tbs_out_reg.sv =====
// ----------------------------------------------------------------------------
// Shaper result register
// Holds one result beat until the consumer takes it; accepts a new beat in
// the same cycle the held one leaves.
// ----------------------------------------------------------------------------
module tbs_out_reg (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  tbs_pkg::rsp_type in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output tbs_pkg::rsp_type out_data
);
   import tbs_pkg::*;

   logic    valid_ff;
   rsp_type data_ff;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   // Track occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   // Load a new beat when the slot frees up
   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= in_data;
      end
   end

endmodule
